/* rtl/pbpa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbpa_pkg
// Shared constants and types for the per-link bad-packet alarm.
// ----------------------------------------------------------------------------
package pbpa_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;

  localparam int LINK_ADDR_W = 32;
  localparam int LOST_W      = 16;
  localparam int COUNT_W     = 8;

  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 8'd3;
  localparam logic [COUNT_W-1:0] COUNTER_MAX     = 8'd255;

  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;

  localparam logic [APB_ADDR_W-1:0] ADDR_ALARM_THRESHOLD = 2'd0;

  typedef struct packed {
    logic [LINK_ADDR_W-1:0] link_addr;
    logic [COUNT_W-1:0]     count;
  } pbpa_entry_t;

endpackage
`default_nettype wire

/* rtl/pbpa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/pbpa_apb.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbpa_apb
// Configuration register file: alarm threshold.
// ----------------------------------------------------------------------------
module pbpa_apb (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pbpa_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pbpa_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pbpa_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output logic [pbpa_pkg::COUNT_W-1:0]    threshold
);
  import pbpa_pkg::*;

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr == ADDR_ALARM_THRESHOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (wr_hit) begin
      threshold <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_ALARM_THRESHOLD) begin
      prdata = {{(APB_DATA_W-COUNT_W){1'b0}}, threshold};
    end
  end

endmodule
`default_nettype wire

/* rtl/pbpa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbpa_ctrl
// Scans the link table in RAM, updates the counter and holds the result.
// ----------------------------------------------------------------------------
module pbpa_ctrl #(
  parameter int TABLE_ENTRIES = pbpa_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pbpa_pkg::LINK_ADDR_W-1:0] link_address,
  input  logic                             crc_good,
  input  logic [pbpa_pkg::LOST_W-1:0]      lost_count,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             alert,
  output logic [pbpa_pkg::LINK_ADDR_W-1:0] alert_address,
  output logic [pbpa_pkg::COUNT_W-1:0]     bad_count,
  output logic                             table_full,
  input  logic [pbpa_pkg::COUNT_W-1:0]     threshold
);
  import pbpa_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int ENT_W = $bits(pbpa_entry_t);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                   state;
  logic [CNT_W-1:0]       fill;
  logic [CNT_W-1:0]       issue_cnt;
  logic [IDX_W-1:0]       rd_idx;
  logic                   rd_pending;

  logic [LINK_ADDR_W-1:0] cur_addr;
  logic                   cur_crc;
  logic [LOST_W-1:0]      cur_lost;

  logic                   scanning;
  logic                   accept;
  logic                   hit;
  logic                   miss;
  logic                   finish;
  logic                   out_free;
  logic                   done;
  logic                   issue;
  logic                   full;
  logic                   bad_rpt;
  logic                   keep_cnt;
  logic [COUNT_W-1:0]     base_cnt;
  logic [COUNT_W-1:0]     new_cnt;

  logic                   ram_wr_en;
  logic [IDX_W-1:0]       ram_wr_addr;
  pbpa_entry_t            ram_wr_data;
  logic [ENT_W-1:0]       ram_rd_raw;
  pbpa_entry_t            ram_rd;

  assign scanning = (state == ST_SCAN);
  assign in_stall = scanning;
  assign accept   = in_valid && !in_stall;

  assign ram_rd   = pbpa_entry_t'(ram_rd_raw);
  assign hit      = scanning && rd_pending && (ram_rd.link_addr == cur_addr);
  assign miss     = scanning && !hit && (issue_cnt == fill);
  assign finish   = hit || miss;
  assign out_free = !out_valid || !out_stall;
  assign done     = finish && out_free;
  assign issue    = scanning && !finish && (issue_cnt != fill);
  assign full     = miss && (fill == CNT_W'(TABLE_ENTRIES));

  assign bad_rpt  = !cur_crc || (cur_lost != '0);
  assign keep_cnt = !cur_crc && (cur_lost != '0);
  assign base_cnt = hit ? ram_rd.count : '0;
  assign new_cnt  = (bad_rpt && (base_cnt != COUNTER_MAX)) ? base_cnt + 1'b1 : base_cnt;

  assign ram_wr_en             = done && !full;
  assign ram_wr_addr           = hit ? rd_idx : fill[IDX_W-1:0];
  assign ram_wr_data.link_addr = cur_addr;
  assign ram_wr_data.count     = keep_cnt ? new_cnt : '0;

  pbpa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (issue),
    .rd_addr (issue_cnt[IDX_W-1:0]),
    .rd_data (ram_rd_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill       <= '0;
      issue_cnt  <= '0;
      rd_pending <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state      <= ST_SCAN;
            issue_cnt  <= '0;
            rd_pending <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (done) begin
            state      <= ST_IDLE;
            rd_pending <= 1'b0;
            if (miss && !full) begin
              fill <= fill + 1'b1;
            end
          end else if (!finish) begin
            rd_pending <= issue;
            if (issue) begin
              issue_cnt <= issue_cnt + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx <= issue_cnt[IDX_W-1:0];
    end
    if (accept) begin
      cur_addr <= link_address;
      cur_crc  <= crc_good;
      cur_lost <= lost_count;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      alert         <= !full && (new_cnt > threshold);
      alert_address <= cur_addr;
      bad_count     <= full ? '0 : new_cnt;
      table_full    <= full;
    end
  end

endmodule
`default_nettype wire

/* rtl/per_link_bad_packet_alarm.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_link_bad_packet_alarm
// Per-link bad-packet counter table with threshold alert.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// in       sink       in_valid / in_stall  link_address, crc_good, lost_count
// out      source     out_valid/ out_stall alert, alert_address, bad_count,
//                                          table_full
// cfg      APB slave  psel/penable/pready  alarm_threshold at byte address 0
//
// An item matching table entry k ends its scan once entry k is read; a new
// or dropped address is compared against all fill entries, where fill is
// the number of stored links. The table RAM is scanned one entry per cycle
// through its single read port; the worst case scans all TABLE_ENTRIES.
// Reset empties the table at once (fill count), no clearing pass.
// A stalled result is held in the output register while the next item scans.
// ----------------------------------------------------------------------------
module per_link_bad_packet_alarm #(
  parameter int TABLE_ENTRIES = pbpa_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pbpa_pkg::LINK_ADDR_W-1:0] link_address,
  input  logic                             crc_good,
  input  logic [pbpa_pkg::LOST_W-1:0]      lost_count,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             alert,
  output logic [pbpa_pkg::LINK_ADDR_W-1:0] alert_address,
  output logic [pbpa_pkg::COUNT_W-1:0]     bad_count,
  output logic                             table_full,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pbpa_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pbpa_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pbpa_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import pbpa_pkg::*;

  logic [COUNT_W-1:0] threshold;

  pbpa_apb u_apb (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .threshold (threshold)
  );

  pbpa_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .link_address  (link_address),
    .crc_good      (crc_good),
    .lost_count    (lost_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .alert         (alert),
    .alert_address (alert_address),
    .bad_count     (bad_count),
    .table_full    (table_full),
    .threshold     (threshold)
  );

endmodule
`default_nettype wire

/* rtl/pbpa_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbpa_checker
// Port-level checks for the per-link bad-packet alarm.
// ----------------------------------------------------------------------------
module pbpa_checker (
  input wire                             clk,
  input wire                             rst,
  input wire                             in_valid,
  input wire                             in_stall,
  input wire                             out_valid,
  input wire                             out_stall,
  input wire                             alert,
  input wire [pbpa_pkg::LINK_ADDR_W-1:0] alert_address,
  input wire [pbpa_pkg::COUNT_W-1:0]     bad_count,
  input wire                             table_full
);
  import pbpa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(alert_address) && $stable(bad_count))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken while previous still scanning");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> !alert && (bad_count == '0))
    else $error("dropped report carries a count or alert");

  a_alert_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && alert |-> (bad_count != '0))
    else $error("alert with zero count");

endmodule

bind per_link_bad_packet_alarm pbpa_checker u_pbpa_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .alert         (alert),
  .alert_address (alert_address),
  .bad_count     (bad_count),
  .table_full    (table_full)
);
`default_nettype wire

/* bench/tb_per_link_bad_packet_alarm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_link_bad_packet_alarm
// Self-checking bench for the per-link bad-packet alarm. A tracker keeps its
// own link table, counters and threshold, predicts the result of every
// accepted report and checks each result in order. A short directed run
// fills the table and covers the edge values, then random phases with bad
// bursts, saturation and dropped reports run at several thresholds, under
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic                             alert;
  logic [pbpa_pkg::LINK_ADDR_W-1:0] link;
  logic [pbpa_pkg::COUNT_W-1:0]     count;
  logic                             full;
} alarm_result_t;

class link_alarm_tracker;
  logic [pbpa_pkg::LINK_ADDR_W-1:0] links [pbpa_pkg::TABLE_ENTRIES_DEF];
  bit                               used [pbpa_pkg::TABLE_ENTRIES_DEF];
  logic [pbpa_pkg::COUNT_W-1:0]     counts [pbpa_pkg::TABLE_ENTRIES_DEF];
  logic [pbpa_pkg::COUNT_W-1:0]     threshold;
  alarm_result_t                    expected_alarms[$];
  int                               errors;

  function new();
    for (int i = 0; i < pbpa_pkg::TABLE_ENTRIES_DEF; i++) begin
      used[i] = 1'b0;
      counts[i] = '0;
      links[i] = '0;
    end
    threshold = pbpa_pkg::THRESHOLD_RESET;
    errors = 0;
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("%0t: MISMATCH %s", $time, msg);
  endfunction

  function void note_report(logic [pbpa_pkg::LINK_ADDR_W-1:0] link_addr, logic crc_ok,
                            logic [pbpa_pkg::LOST_W-1:0] lost);
    int                           slot;
    logic [pbpa_pkg::COUNT_W-1:0] cnt;
    alarm_result_t                r;
    slot = -1;
    for (int i = 0; i < pbpa_pkg::TABLE_ENTRIES_DEF; i++)
      if (slot < 0 && used[i] && links[i] == link_addr) slot = i;
    for (int i = 0; i < pbpa_pkg::TABLE_ENTRIES_DEF; i++)
      if (slot < 0 && !used[i]) begin
        used[i] = 1'b1;
        links[i] = link_addr;
        counts[i] = '0;
        slot = i;
      end
    r.link = link_addr;
    if (slot < 0) begin
      r.alert = 1'b0;
      r.count = '0;
      r.full = 1'b1;
    end else begin
      cnt = counts[slot];
      if ((!crc_ok || lost != 0) && cnt != pbpa_pkg::COUNTER_MAX) cnt++;
      r.alert = (cnt > threshold);
      r.count = cnt;
      r.full = 1'b0;
      if (crc_ok || lost == 0) cnt = '0;
      counts[slot] = cnt;
    end
    expected_alarms.push_back(r);
  endfunction

  function void check_alarm(alarm_result_t got);
    alarm_result_t exp;
    if (expected_alarms.size() == 0) begin
      flag($sformatf("unexpected result alert=%0b link=%08h count=%0d full=%0b",
                     got.alert, got.link, got.count, got.full));
      return;
    end
    exp = expected_alarms.pop_front();
    if (got.alert !== exp.alert || got.link !== exp.link || got.count !== exp.count ||
        got.full !== exp.full)
      flag($sformatf({"exp alert=%0b link=%08h count=%0d full=%0b, ",
                      "got alert=%0b link=%08h count=%0d full=%0b"},
                     exp.alert, exp.link, exp.count, exp.full,
                     got.alert, got.link, got.count, got.full));
  endfunction
endclass

module tb_per_link_bad_packet_alarm;

  localparam logic [31:0] DROPPED_LINK = 32'hA5A5_5A5A;

  logic                             clk;
  logic                             rst;
  logic                             in_valid;
  logic                             in_stall;
  logic [pbpa_pkg::LINK_ADDR_W-1:0] link_address;
  logic                             crc_good;
  logic [pbpa_pkg::LOST_W-1:0]      lost_count;
  logic                             out_valid;
  logic                             out_stall;
  logic                             alert;
  logic [pbpa_pkg::LINK_ADDR_W-1:0] alert_address;
  logic [pbpa_pkg::COUNT_W-1:0]     bad_count;
  logic                             table_full;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [pbpa_pkg::APB_ADDR_W-1:0]  paddr;
  logic [pbpa_pkg::APB_DATA_W-1:0]  pwdata;
  logic [pbpa_pkg::APB_DATA_W-1:0]  prdata;
  logic                             pready;

  link_alarm_tracker tracker = new();

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic [31:0] link_pool [16];

  per_link_bad_packet_alarm dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .link_address(link_address), .crc_good(crc_good), .lost_count(lost_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .alert(alert), .alert_address(alert_address), .bad_count(bad_count),
    .table_full(table_full),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_alarm({alert, alert_address, bad_count, table_full});
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_report(input logic [31:0] a, input logic c, input logic [15:0] l);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    link_address <= a;
    crc_good <= c;
    lost_count <= l;
    do @(posedge clk); while (in_stall);
    tracker.note_report(a, c, l);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.expected_alarms.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write then read back; psel held high across both
  task automatic write_threshold(input logic [7:0] thr);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= pbpa_pkg::ADDR_ALARM_THRESHOLD;
    pwdata <= {24'($urandom), thr};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.threshold = thr;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'h0, thr})
      tracker.flag($sformatf("threshold read exp %08h got %08h", {24'h0, thr}, prdata));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input int n, input logic [7:0] thr, input int s_pct,
                           input int r_pct, input bit saturate);
    int          burst_left;
    int          roll;
    logic [31:0] burst_link;
    logic [31:0] a;
    logic        c;
    logic [15:0] l;
    drain();
    write_threshold(thr);
    send_idle_pct = s_pct;
    stall_pct = r_pct;
    burst_left = saturate ? 258 : 0;
    burst_link = link_pool[3];
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 199) == 0) drain();
      roll = $urandom_range(0, 99);
      if (burst_left == 0 && roll < 25) begin
        burst_link = link_pool[$urandom_range(0, 15)];
        burst_left = $urandom_range(2, 20);
      end
      if (burst_left > 0) begin
        a = burst_link;
        c = 1'b0;
        l = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                        : 16'($urandom_range(1, 3));
        burst_left--;
      end else begin
        a = (roll < 37) ? $urandom : link_pool[$urandom_range(0, 15)];
        c = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 9);
        l = (roll < 4) ? 16'h0 : (roll < 7) ? 16'($urandom_range(1, 3)) : 16'($urandom);
      end
      send_report(a, c, l);
    end
  endtask

  initial begin
    logic [31:0] cand;
    bit          clash;
    rst <= 1'b1;
    in_valid <= 1'b0;
    link_address <= '0;
    crc_good <= 1'b0;
    lost_count <= '0;
    out_stall <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    link_pool[0] = 32'h0000_0000;
    link_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 16; i++) begin
      do begin
        cand = $urandom;
        clash = (cand == DROPPED_LINK);
        for (int j = 0; j < i; j++) if (link_pool[j] == cand) clash = 1'b1;
      end while (clash);
      link_pool[i] = cand;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset threshold, clear rule, table fill, dropped reports
    send_report(link_pool[0], 1'b1, 16'h0000);
    send_report(link_pool[0], 1'b0, 16'hFFFF);
    send_report(link_pool[0], 1'b0, 16'h0001);
    send_report(link_pool[0], 1'b0, 16'h0001);
    send_report(link_pool[0], 1'b0, 16'hFFFF);
    send_report(link_pool[0], 1'b0, 16'h0000);
    send_report(link_pool[0], 1'b1, 16'h0005);
    send_report(link_pool[1], 1'b0, 16'h0000);
    for (int i = 2; i < 16; i++)
      send_report(link_pool[i], 1'($urandom_range(0, 1)), 16'($urandom));
    send_report(DROPPED_LINK, 1'b1, 16'h0000);
    send_report(DROPPED_LINK, 1'b0, 16'h8000);
    send_report(link_pool[1], 1'b0, 16'h8000);

    run_phase(270, 8'd0,   0,  0,  1'b0);
    run_phase(270, 8'd255, 0,  0,  1'b1);
    run_phase(270, 8'($urandom_range(1, 20)), 80, 0, 1'b0);
    run_phase(270, 8'd1,   0,  80, 1'b0);
    run_phase(270, 8'd254, 33, 33, 1'b0);
    run_phase(270, 8'($urandom_range(2, 12)), 0, 0, 1'b0);

    drain();
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_alarms.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* files.f */
rtl/pbpa_pkg.sv
rtl/pbpa_ram.sv
rtl/pbpa_apb.sv
rtl/pbpa_ctrl.sv
rtl/per_link_bad_packet_alarm.sv
rtl/pbpa_checker.sv
bench/tb_per_link_bad_packet_alarm.sv
